[sv/ldif_line_to_json_stream_assert.svh]
// assertion macros for the line-to-json stream block
// included by the top level; needs nothing else
`ifndef LDIF_LINE_TO_JSON_STREAM_ASSERT_SVH
`define LDIF_LINE_TO_JSON_STREAM_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LDIF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LDIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ldif_pkg.sv]
// shared types and character codes for the line-to-json stream block
// no dependencies
package ldif_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_VRD,
		ST_VEM,
		ST_POST
	} st_t;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	// depth of the fixed character lists around a value
	localparam int unsigned PRE_DEPTH  = 5;
	localparam int unsigned POST_DEPTH = 3;

endpackage

[sv/ldif_line_to_json_stream.sv]
// top level of the line-to-json stream block: parser, value buffer and output sequencer
// depends on ldif_pkg and ldif_line_to_json_stream_assert.svh
//
// Usage
//   Input channel s_*: one text byte per transaction on s_tdata, s_tuser set marks end
//   of stream (byte ignored then). Output channel m_*: one JSON character per
//   transaction on m_tdata, m_tlast on the final character caused by an input
//   transaction, m_tuser set when value bytes were dropped since the last flush.
// Timing
//   Characters of an input transaction follow from a character list (up to five
//   before a value, up to three after), one after another, and a flushed value is
//   walked from the value memory byte by byte (synchronous read in ST_VRD, then emit in
//   ST_VEM). s_tready is high again once the last character of a transaction has
//   entered the output register. The first character passes the sequencer state, then
//   the output register; when it is a value byte, the value memory read comes first.
// Reset
//   arst_n resets the parser flags, the sequencer state and the output valid flag;
//   the value memory is not cleared; only entries written since the last flush are read.
// Stall
//   When m_tready is low with a character pending, the output register holds and the sequencer waits;
//   no character is lost or repeated.
`include "ldif_line_to_json_stream_assert.svh"

module ldif_line_to_json_stream #(
	parameter int unsigned VALUE_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] end_of_stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,
	output logic       m_tuser    // [0] overflow
);

	localparam int unsigned LW = $clog2(VALUE_MAX + 1);
	localparam int unsigned IW = $clog2(VALUE_MAX);
	localparam logic [LW-1:0] LEN_MAX = LW'(VALUE_MAX);

	// parser state
	logic started_q, finished_q, in_value_q, skip_q, after_nl_q;
	logic in_comment_q, comment_ended_q, numeric_q, dropped_q;
	logic [LW-1:0] len_q;

	// sequencer state
	ldif_pkg::st_t st_q, st_nxt;
	logic [ldif_pkg::PRE_DEPTH-1:0][7:0]  pre_q;
	logic [2:0]                           pre_cnt_q;
	logic [ldif_pkg::POST_DEPTH-1:0][7:0] post_q;
	logic [1:0]                           post_cnt_q;
	logic [LW-1:0] walk_len_q, idx_q;
	logic          ov_q;
	logic [7:0]    rdata_q;

	// output register
	logic       m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [7:0] m_tdata_q;

	// value memory
	logic [7:0] mem [VALUE_MAX];

	// decode results
	logic d_started, d_finished, d_in_value, d_skip, d_after_nl;
	logic d_in_comment, d_comment_ended, d_numeric, d_dropped, d_ov, d_wr;
	logic [LW-1:0] d_len, d_walk_len;
	logic [ldif_pkg::PRE_DEPTH-1:0][7:0]  d_pre;
	logic [2:0]                           d_pre_cnt;
	logic [ldif_pkg::POST_DEPTH-1:0][7:0] d_post;
	logic [1:0]                           d_post_cnt;
	ldif_pkg::st_t d_st;
	logic ic, take, flush, quote;

	logic accept, out_free, emit, emit_last;
	logic [7:0] emit_char;
	logic walk_pend, walk_end;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (st_q == ldif_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign walk_pend = (walk_len_q != '0);
	assign walk_end  = (LW'(idx_q + 1'b1) == walk_len_q);

	// decode one input transaction against the parser state
	always_comb begin
		d_started       = started_q;
		d_finished      = finished_q;
		d_in_value      = in_value_q;
		d_skip          = skip_q;
		d_after_nl      = after_nl_q;
		d_in_comment    = in_comment_q;
		d_comment_ended = comment_ended_q;
		d_numeric       = numeric_q;
		d_dropped       = dropped_q;
		d_len           = len_q;
		d_walk_len      = '0;
		d_pre           = '0;
		d_pre_cnt       = '0;
		d_post          = '0;
		d_post_cnt      = '0;
		d_wr            = 1'b0;
		d_ov            = 1'b0;
		ic              = in_comment_q;
		take            = 1'b0;
		flush           = 1'b0;
		quote           = 1'b0;
		if (!finished_q) begin
			if (!started_q) begin
				d_pre[d_pre_cnt] = ldif_pkg::CH_LBRACE;
				d_pre_cnt = d_pre_cnt + 3'd1;
				d_pre[d_pre_cnt] = ldif_pkg::CH_QUOTE;
				d_pre_cnt = d_pre_cnt + 3'd1;
				d_started = 1'b1;
			end
			if (s_tuser) begin
				flush      = 1'b1;
				d_finished = 1'b1;
			end else if (s_tdata == ldif_pkg::CH_NUL) begin
				d_finished = 1'b1;
			end else begin
				if (s_tdata == ldif_pkg::CH_HASH && !in_value_q) begin
					ic           = 1'b1;
					d_in_comment = 1'b1;
				end
				case (s_tdata)
					ldif_pkg::CH_COLON: begin
						if (!ic) begin
							if (in_value_q) begin
								take = 1'b1;
							end else begin
								d_pre[d_pre_cnt] = ldif_pkg::CH_QUOTE;
								d_pre_cnt = d_pre_cnt + 3'd1;
								d_pre[d_pre_cnt] = ldif_pkg::CH_COLON;
								d_pre_cnt = d_pre_cnt + 3'd1;
								d_pre[d_pre_cnt] = ldif_pkg::CH_SPACE;
								d_pre_cnt = d_pre_cnt + 3'd1;
								d_in_value = 1'b1;
								d_skip     = 1'b1;
							end
						end
					end
					ldif_pkg::CH_SPACE: begin
						if (!ic && !skip_q) begin
							if (in_value_q) begin
								take = 1'b1;
							end else begin
								d_pre[d_pre_cnt] = ldif_pkg::CH_SPACE;
								d_pre_cnt = d_pre_cnt + 3'd1;
							end
						end
					end
					ldif_pkg::CH_LF: begin
						if (!ic && !comment_ended_q) begin
							if (in_value_q) begin
								flush      = 1'b1;
								d_in_value = 1'b0;
								d_skip     = 1'b0;
								d_after_nl = 1'b1;
							end
						end else begin
							d_in_comment    = 1'b0;
							d_comment_ended = 1'b1;
						end
					end
					default: begin
						if (!ic) begin
							if (after_nl_q) begin
								d_pre[d_pre_cnt] = ldif_pkg::CH_COMMA;
								d_pre_cnt = d_pre_cnt + 3'd1;
								d_pre[d_pre_cnt] = ldif_pkg::CH_QUOTE;
								d_pre_cnt = d_pre_cnt + 3'd1;
							end
							if (in_value_q) begin
								take = 1'b1;
							end else begin
								d_pre[d_pre_cnt] = s_tdata;
								d_pre_cnt = d_pre_cnt + 3'd1;
							end
							d_skip          = 1'b0;
							d_after_nl      = 1'b0;
							d_comment_ended = 1'b0;
						end
					end
				endcase
			end
			// buffer a value byte, classify it even when dropped
			if (take) begin
				if (!(s_tdata inside {[ldif_pkg::CH_DIG0:ldif_pkg::CH_DIG9], ldif_pkg::CH_DOT}))
					d_numeric = 1'b0;
				if (len_q < LEN_MAX) begin
					d_wr  = 1'b1;
					d_len = LW'(len_q + 1'b1);
				end else begin
					d_dropped = 1'b1;
				end
			end
			// flush: quotes around a non-numeric value, then restart the buffer
			if (flush) begin
				quote = !numeric_q;
				if (quote) begin
					d_pre[d_pre_cnt] = ldif_pkg::CH_QUOTE;
					d_pre_cnt = d_pre_cnt + 3'd1;
					d_post[d_post_cnt] = ldif_pkg::CH_QUOTE;
					d_post_cnt = d_post_cnt + 2'd1;
				end
				if (s_tuser) begin
					d_post[d_post_cnt] = ldif_pkg::CH_RBRACE;
					d_post_cnt = d_post_cnt + 2'd1;
					d_post[d_post_cnt] = ldif_pkg::CH_LF;
					d_post_cnt = d_post_cnt + 2'd1;
				end
				d_walk_len = len_q;
				d_ov       = dropped_q;
				d_numeric  = 1'b1;
				d_len      = '0;
				d_dropped  = 1'b0;
			end else begin
				d_ov = d_dropped;
			end
		end
		// first sequencer state for this transaction
		if (d_pre_cnt != 3'd0)
			d_st = ldif_pkg::ST_PRE;
		else if (d_walk_len != '0)
			d_st = ldif_pkg::ST_VRD;
		else if (d_post_cnt != 2'd0)
			d_st = ldif_pkg::ST_POST;
		else
			d_st = ldif_pkg::ST_IDLE;
	end

	// sequencer next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ldif_pkg::ST_IDLE: begin
				if (accept)
					st_nxt = d_st;
			end
			ldif_pkg::ST_PRE: begin
				if (out_free && pre_cnt_q == 3'd1) begin
					if (walk_pend)
						st_nxt = ldif_pkg::ST_VRD;
					else if (post_cnt_q != 2'd0)
						st_nxt = ldif_pkg::ST_POST;
					else
						st_nxt = ldif_pkg::ST_IDLE;
				end
			end
			ldif_pkg::ST_VRD: st_nxt = ldif_pkg::ST_VEM;
			ldif_pkg::ST_VEM: begin
				if (out_free) begin
					if (!walk_end)
						st_nxt = ldif_pkg::ST_VRD;
					else if (post_cnt_q != 2'd0)
						st_nxt = ldif_pkg::ST_POST;
					else
						st_nxt = ldif_pkg::ST_IDLE;
				end
			end
			ldif_pkg::ST_POST: begin
				if (out_free && post_cnt_q == 2'd1)
					st_nxt = ldif_pkg::ST_IDLE;
			end
			default: st_nxt = ldif_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: which character goes to the output register
	always_comb begin
		emit      = 1'b0;
		emit_char = '0;
		emit_last = 1'b0;
		case (st_q)
			ldif_pkg::ST_PRE: begin
				emit      = out_free;
				emit_char = pre_q[0];
				emit_last = (pre_cnt_q == 3'd1) && !walk_pend && (post_cnt_q == 2'd0);
			end
			ldif_pkg::ST_VEM: begin
				emit      = out_free;
				emit_char = rdata_q;
				emit_last = walk_end && (post_cnt_q == 2'd0);
			end
			ldif_pkg::ST_POST: begin
				emit      = out_free;
				emit_char = post_q[0];
				emit_last = (post_cnt_q == 2'd1);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// parser flags and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ldif_pkg::ST_IDLE;
			started_q       <= 1'b0;
			finished_q      <= 1'b0;
			in_value_q      <= 1'b0;
			skip_q          <= 1'b0;
			after_nl_q      <= 1'b0;
			in_comment_q    <= 1'b0;
			comment_ended_q <= 1'b0;
			numeric_q       <= 1'b1;
			dropped_q       <= 1'b0;
			len_q           <= '0;
			pre_cnt_q       <= '0;
			post_cnt_q      <= '0;
			walk_len_q      <= '0;
			idx_q           <= '0;
			ov_q            <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (accept) begin
				started_q       <= d_started;
				finished_q      <= d_finished;
				in_value_q      <= d_in_value;
				skip_q          <= d_skip;
				after_nl_q      <= d_after_nl;
				in_comment_q    <= d_in_comment;
				comment_ended_q <= d_comment_ended;
				numeric_q       <= d_numeric;
				dropped_q       <= d_dropped;
				len_q           <= d_len;
				pre_cnt_q       <= d_pre_cnt;
				post_cnt_q      <= d_post_cnt;
				walk_len_q      <= d_walk_len;
				idx_q           <= '0;
				ov_q            <= d_ov;
			end else if (emit) begin
				case (st_q)
					ldif_pkg::ST_PRE:  pre_cnt_q  <= pre_cnt_q - 3'd1;
					ldif_pkg::ST_VEM:  idx_q      <= LW'(idx_q + 1'b1);
					ldif_pkg::ST_POST: post_cnt_q <= post_cnt_q - 2'd1;
					default:           idx_q      <= idx_q;
				endcase
			end
		end
	end

	// character lists, loaded on a transaction and shifted as they drain
	always_ff @(posedge clk) begin
		if (accept) begin
			pre_q  <= d_pre;
			post_q <= d_post;
		end else if (emit && st_q == ldif_pkg::ST_PRE) begin
			pre_q <= {8'h00, pre_q[ldif_pkg::PRE_DEPTH-1:1]};
		end else if (emit && st_q == ldif_pkg::ST_POST) begin
			post_q <= {8'h00, post_q[ldif_pkg::POST_DEPTH-1:1]};
		end
	end

	// value memory: write on buffered byte, read while walking a flush
	always_ff @(posedge clk) begin
		if (accept && d_wr)
			mem[len_q[IW-1:0]] <= s_tdata;
	end

	always_ff @(posedge clk) begin
		if (st_q == ldif_pkg::ST_VRD)
			rdata_q <= mem[idx_q[IW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= emit_last;
			m_tuser_q <= ov_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// checks on buffer bookkeeping and sequencing
	`LDIF_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_MAX, "value length beyond buffer")
	`LDIF_ASSERT_NOW(a_drop_full, clk, arst_n, dropped_q, len_q == LEN_MAX, "byte dropped with room left")
	`LDIF_ASSERT_NOW(a_walk_idx, clk, arst_n, (st_q == ldif_pkg::ST_VRD) || (st_q == ldif_pkg::ST_VEM), idx_q < walk_len_q, "value walk past its length")
	`LDIF_ASSERT_NEXT(a_last_idle, clk, arst_n, emit && emit_last, st_q == ldif_pkg::ST_IDLE, "last character did not end the sequence")
	`LDIF_ASSERT_NEXT(a_fin_quiet, clk, arst_n, (st_q == ldif_pkg::ST_IDLE) && finished_q, st_q == ldif_pkg::ST_IDLE, "output after end of stream")

endmodule

[sim/testbench.sv]
// self-checking testbench for the line-to-json stream block
// drives text bytes and checks every json character against a built-in predictor
// depends on ldif_pkg and the ldif_line_to_json_stream top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUE_MAX    = 32;
	localparam int          RESET_CYCLES = 12;
	localparam int          STREAM_ITEMS = 300;
	localparam int          LONG_HOLD    = 400;
	localparam int          TAIL_CYCLES  = 150;
	localparam longint      TIMEOUT_NS   = 4_000_000;

	// one emitted json character with its flags
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
	} json_char_t;

	// predictor of the json text plus the queue of characters still owed
	class json_scoreboard;
		json_char_t  expected_q[$];
		logic [7:0]  step_chars[$];
		logic [7:0]  value_mem[VALUE_MAX];
		bit          opened, done, in_value, skip_space, after_newline;
		bit          in_comment, comment_ended, numeric, dropped;
		int unsigned value_len;
		int unsigned inputs, checked, errors;
		int unsigned bare_values, quoted_values, clipped_values;

		function new();
			numeric = 1'b1;
		endfunction

		// buffer one value byte, dropping it when the buffer is full
		function void take_byte(logic [7:0] b);
			if (!((b >= ldif_pkg::CH_DIG0 && b <= ldif_pkg::CH_DIG9) || b == ldif_pkg::CH_DOT))
				numeric = 1'b0;
			if (value_len < VALUE_MAX) begin
				value_mem[value_len] = b;
				value_len++;
			end else begin
				dropped = 1'b1;
			end
		endfunction

		// write the buffered value, quoted unless empty or digits and dots only
		function void flush_value();
			bit quoted;
			quoted = !numeric;
			if (quoted)
				step_chars.push_back(ldif_pkg::CH_QUOTE);
			for (int i = 0; i < value_len; i++)
				step_chars.push_back(value_mem[i]);
			if (quoted) begin
				step_chars.push_back(ldif_pkg::CH_QUOTE);
				quoted_values++;
			end else begin
				bare_values++;
			end
			if (dropped)
				clipped_values++;
			value_len = 0;
			numeric = 1'b1;
			dropped = 1'b0;
		endfunction

		// work out the characters caused by one accepted input transaction
		function void note_input(logic [7:0] b, logic eos);
			bit         flushed, old_drop, ovf_now;
			json_char_t c;
			flushed = 1'b0;
			old_drop = 1'b0;
			inputs++;
			if (done)
				return;
			step_chars.delete();
			if (!opened) begin
				step_chars.push_back(ldif_pkg::CH_LBRACE);
				step_chars.push_back(ldif_pkg::CH_QUOTE);
				opened = 1'b1;
			end
			if (eos) begin
				old_drop = dropped;
				flushed = 1'b1;
				flush_value();
				step_chars.push_back(ldif_pkg::CH_RBRACE);
				step_chars.push_back(ldif_pkg::CH_LF);
				done = 1'b1;
			end else if (b == ldif_pkg::CH_NUL) begin
				done = 1'b1;
			end else begin
				if (b == ldif_pkg::CH_HASH && !in_value)
					in_comment = 1'b1;
				if (b == ldif_pkg::CH_COLON) begin
					if (!in_comment) begin
						if (in_value) begin
							take_byte(b);
						end else begin
							step_chars.push_back(ldif_pkg::CH_QUOTE);
							step_chars.push_back(ldif_pkg::CH_COLON);
							step_chars.push_back(ldif_pkg::CH_SPACE);
							in_value = 1'b1;
							skip_space = 1'b1;
						end
					end
				end else if (b == ldif_pkg::CH_SPACE) begin
					if (!in_comment && !skip_space) begin
						if (in_value)
							take_byte(b);
						else
							step_chars.push_back(ldif_pkg::CH_SPACE);
					end
				end else if (b == ldif_pkg::CH_LF) begin
					if (!in_comment && !comment_ended) begin
						if (in_value) begin
							old_drop = dropped;
							flushed = 1'b1;
							flush_value();
							in_value = 1'b0;
							skip_space = 1'b0;
							after_newline = 1'b1;
						end
					end else begin
						in_comment = 1'b0;
						comment_ended = 1'b1;
					end
				end else if (!in_comment) begin
					if (after_newline) begin
						step_chars.push_back(ldif_pkg::CH_COMMA);
						step_chars.push_back(ldif_pkg::CH_QUOTE);
					end
					if (in_value)
						take_byte(b);
					else
						step_chars.push_back(b);
					skip_space = 1'b0;
					after_newline = 1'b0;
					comment_ended = 1'b0;
				end
			end
			// overflow reports the flushed value on a flushing step
			ovf_now = flushed ? old_drop : dropped;
			foreach (step_chars[i]) begin
				c.ch = step_chars[i];
				c.last = (i == step_chars.size() - 1);
				c.ovf = ovf_now;
				expected_q.push_back(c);
			end
		endfunction

		// compare one output transaction with the oldest expected character
		function void check_char(logic [7:0] ch, logic last, logic ovf);
			json_char_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected character %02h last %0b overflow %0b at %0t",
						ch, last, ovf, $realtime);
				return;
			end
			want = expected_q.pop_front();
			if (ch !== want.ch || last !== want.last || ovf !== want.ovf) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch at character %0d: expected %02h last %0b overflow %0b,",
						" got %02h last %0b overflow %0b"}, checked, want.ch, want.last,
						want.ovf, ch, last, ovf);
			end
		endfunction
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tuser  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	json_scoreboard sb = new();

	int         items_sent = 0;
	int         burst_left = 0;
	bit         steady = 1'b0;
	logic [3:0] hold_asked = 4'd0;
	logic [3:0] hold_seen = 4'd0;
	int         hold_cnt = 0;
	logic [9:0] rx_tick = 10'd0;

	ldif_line_to_json_stream #(
		.VALUE_MAX(VALUE_MAX)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d characters outstanding", sb.expected_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				sb.check_char(m_tdata, m_tlast, m_tuser);
		end
	end

	// receiver: rotating stall patterns plus a long hold on request
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_cnt <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_tick[9:8])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= ($urandom_range(0, 3) != 0);
				2'd2: m_tready <= (rx_tick[2:0] < 3'd5);
				default: m_tready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// sender bursts with random gaps in between
	task automatic pace();
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 3);
				2: gap = $urandom_range(4, 12);
				default: gap = $urandom_range(0, 1);
			endcase
		end
		burst_left--;
		if (gap > 0 && !steady) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// offer one byte and wait for its transaction
	task automatic send_item(input logic [7:0] b, input logic eos);
		pace();
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eos;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(txt[i], 1'b0);
	endtask

	// key bytes: mostly letters, some spaces and arbitrary bytes
	function automatic logic [7:0] key_byte();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = 8'($urandom_range(1, 255));
			1: b = ldif_pkg::CH_SPACE;
			default: b = 8'($urandom_range(8'h61, 8'h7a));
		endcase
		if (b == ldif_pkg::CH_COLON || b == ldif_pkg::CH_LF || b == ldif_pkg::CH_HASH)
			b = ldif_pkg::CH_DOT;
		return b;
	endfunction

	function automatic logic [7:0] num_byte();
		logic [7:0] b;
		if ($urandom_range(0, 10) == 0)
			b = ldif_pkg::CH_DOT;
		else
			b = ldif_pkg::CH_DIG0 + 8'($urandom_range(0, 9));
		return b;
	endfunction

	// value bytes: any nonzero byte except newline, colons, spaces and hashes favored
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = 8'($urandom_range(1, 255));
			1: b = ldif_pkg::CH_COLON;
			2: b = ldif_pkg::CH_SPACE;
			3: b = ldif_pkg::CH_HASH;
			default: b = 8'($urandom_range(8'h21, 8'h7e));
		endcase
		if (b == ldif_pkg::CH_LF)
			b = ldif_pkg::CH_SPACE;
		return b;
	endfunction

	// one "key: value" line; kind 0 empty, 1 number, 2 text, 3 long number, 4 long text
	task automatic send_record(input int vkind);
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_item(key_byte(), 1'b0);
		send_item(ldif_pkg::CH_COLON, 1'b0);
		n = $urandom_range(0, 3);
		repeat (n) send_item(ldif_pkg::CH_SPACE, 1'b0);
		case (vkind)
			0: n = 0;
			1: n = $urandom_range(1, 8);
			2: n = $urandom_range(1, 10);
			default: n = $urandom_range(VALUE_MAX - 2, VALUE_MAX + 12);
		endcase
		for (int i = 0; i < n; i++)
			send_item((vkind == 1 || vkind == 3) ? num_byte() : text_byte(), 1'b0);
		send_item(ldif_pkg::CH_LF, 1'b0);
		if ($urandom_range(0, 7) == 0)
			send_item(ldif_pkg::CH_LF, 1'b0);
	endtask

	// stimulus
	initial begin
		int  pick;
		int  n;
		bit  hold_done;
		bit  drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: opening brace, skipped spaces, bare number, comment and the
		// newline after it, colon and high byte inside a quoted value, empty value,
		// space and high byte in a key, hash inside a value
		send_text("a: 1.5\n");
		send_text("#c\n\n");
		send_text("b:  x:");
		send_item(8'hff, 1'b0);
		send_text("\"\n");
		send_text("c:\n");
		send_item(8'h80, 1'b0);
		send_text(" k:9#\n");

		// random: mostly well-formed lines, some comments, noise and broken lines
		while (items_sent < STREAM_ITEMS) begin
			if (!hold_done && items_sent >= 100) begin
				hold_asked <= hold_asked + 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= 200) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.expected_q.size() != 0);
				drain_done = 1'b1;
			end
			steady = (items_sent >= 230 && items_sent < 270);
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				send_record($urandom_range(0, 2));
			end else if (pick < 72) begin
				send_record($urandom_range(3, 4));
			end else if (pick < 82) begin
				send_item(ldif_pkg::CH_HASH, 1'b0);
				n = $urandom_range(0, 8);
				repeat (n) send_item(text_byte(), 1'b0);
				send_item(ldif_pkg::CH_LF, 1'b0);
				if ($urandom_range(0, 3) == 0)
					send_item(ldif_pkg::CH_LF, 1'b0);
			end else if (pick < 92) begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(8'($urandom_range(1, 255)), 1'b0);
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_item(key_byte(), 1'b0);
				case ($urandom_range(0, 2))
					0: send_item(ldif_pkg::CH_LF, 1'b0);
					1: begin
						send_item(ldif_pkg::CH_COLON, 1'b0);
						send_item(ldif_pkg::CH_COLON, 1'b0);
						send_item(ldif_pkg::CH_LF, 1'b0);
					end
					default: begin
						send_item(ldif_pkg::CH_COLON, 1'b0);
						repeat (n) send_item(text_byte(), 1'b0);
					end
				endcase
			end
		end

		// end of stream, either closing the object or stopping on a zero byte
		if ($urandom_range(0, 3) == 0) begin
			send_item(ldif_pkg::CH_NUL, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
			send_item(ldif_pkg::CH_NUL, 1'b0);
		end
		repeat (5) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		// drain and let any stray characters show up
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input transactions and %0d output characters",
			sb.inputs, sb.checked);
		$display("values: %0d bare, %0d quoted, %0d clipped; %0d mismatches",
			sb.bare_values, sb.quoted_values, sb.clipped_values, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
